// File: rtl/core/b64le_pkg.sv
// Shared types, constants and the alphabet lookup for the line-wrapped base64 encoder.
package b64le_pkg;

    localparam logic [7:0] LINE_LEN_RESET = 8'd76;
    localparam logic [7:0] LINE_LEN_MIN   = 8'd4;
    localparam logic [7:0] CHAR_PAD       = 8'h3D;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;

    // Slot count of a frame with and without an inserted CR LF.
    localparam logic [2:0] FRAME_SHORT = 3'd4;
    localparam logic [2:0] FRAME_LONG  = 3'd6;
    // Break position meaning "no CR LF in this group".
    localparam logic [2:0] BRK_NONE    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    typedef struct packed {
        logic [5:0][7:0] chars;
        logic [2:0]      cnt;
        logic            fin;
    } t_frame;

    // Standard base64 alphabet.
    function automatic logic [7:0] enc6(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return CHAR_UPPER_A + w;
        else if (v < 6'd52) return CHAR_LOWER_A + (w - 8'd26);
        else if (v < 6'd62) return CHAR_DIGIT_0 + (w - 8'd52);
        else if (v == 6'd62) return CHAR_PLUS;
        else                return CHAR_SLASH;
    endfunction

endpackage

// File: rtl/core/b64le_frame.sv
// Builds one output frame (four characters, padding, optional CR LF) from a completed group.
module b64le_frame (
    input  logic [15:0]       i_held,
    input  logic [1:0]        i_fill,
    input  logic [7:0]        i_byte,
    input  logic              i_final,
    input  logic [7:0]        i_pos,
    input  logic [7:0]        i_line_len,
    output b64le_pkg::t_frame o_frame,
    output logic [7:0]        o_next_pos
);
    import b64le_pkg::*;

    logic [7:0]      b0, b1, b2;
    logic [3:0][7:0] c;
    logic [7:0]      limit;
    logic [7:0]      room;
    logic [2:0]      brk;

    always_comb begin
        b0 = '0;
        b1 = '0;
        b2 = '0;
        case (i_fill)
            2'd0: begin
                b0 = i_byte;
            end
            2'd1: begin
                b0 = i_held[7:0];
                b1 = i_byte;
            end
            default: begin
                b0 = i_held[15:8];
                b1 = i_held[7:0];
                b2 = i_byte;
            end
        endcase

        c[0] = enc6(b0[7:2]);
        c[1] = enc6({b0[1:0], b1[7:4]});
        c[2] = enc6({b1[3:0], b2[7:6]});
        c[3] = enc6(b2[5:0]);
        if (i_fill == 2'd0) c[2] = CHAR_PAD;
        if (i_fill != 2'd2) c[3] = CHAR_PAD;
    end

    // At most one CR LF per group since the limit is at least four.
    always_comb begin
        limit = (i_line_len < LINE_LEN_MIN) ? LINE_LEN_MIN : i_line_len;
        room  = limit - i_pos;
        if (i_pos >= limit)    brk = 3'd0;
        else if (room < 8'd4)  brk = room[2:0];
        else                   brk = BRK_NONE;

        if (i_final)               o_next_pos = '0;
        else if (brk == BRK_NONE)  o_next_pos = i_pos + 8'd4;
        else                       o_next_pos = 8'd4 - {5'd0, brk};
    end

    always_comb begin
        o_frame.fin = i_final;
        o_frame.cnt = (brk == BRK_NONE) ? FRAME_SHORT : FRAME_LONG;
        for (int s = 0; s < 6; s++) begin
            if (brk == BRK_NONE) begin
                o_frame.chars[s] = (s < 4) ? c[2'(s)] : 8'h00;
            end else if (3'(s) < brk) begin
                o_frame.chars[s] = c[2'(s)];
            end else if (3'(s) == brk) begin
                o_frame.chars[s] = CHAR_CR;
            end else if (3'(s) == brk + 3'd1) begin
                o_frame.chars[s] = CHAR_LF;
            end else begin
                o_frame.chars[s] = c[2'(s - 2)];
            end
        end
    end

endmodule

// File: rtl/core/base64_line_wrapped_encoder_top.sv
// Top level of the line-wrapped base64 encoder: byte collection, frame register, output beats.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data): one raw byte per beat,
//   final_byte set on the last byte of a message. Output channel (o_out_valid /
//   i_out_ready / o_out_data): one character per beat, run_last on the last
//   character caused by an input beat, message_end on the last character of a
//   message. Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   line length; o_cfg_ready is always high. Write it only while idle. Values
//   below 4 act as 4.
//   Latency: a group-completing byte is encoded in its accept cycle into the
//   frame register; its first character is on the output the next cycle.
//   Throughput: one output beat per cycle while i_out_ready is high; a group
//   gives four characters (six with a CR LF). Bytes that only fill the group
//   are taken while the previous frame drains, so the sustained byte rate is
//   set by the single output port on the frame register.
//   Reset (i_rst_n low, synchronous): group and line position cleared, line
//   length back to 76, no frame pending.
//   Output stall: the frame holds; fill bytes are still accepted, but a byte
//   that completes a group waits until the frame's last beat is taken.
module base64_line_wrapped_encoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  b64le_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output b64le_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    import b64le_pkg::*;

    // Group collection and line state
    logic [15:0] r_held;
    logic [1:0]  r_fill;
    logic [7:0]  r_pos;
    logic [7:0]  r_len;

    // Frame register: the pending output characters of one group
    t_frame      r_frame;
    logic        r_fv;
    logic [2:0]  r_idx;

    t_frame      n_frame;
    logic [7:0]  n_pos;

    logic in_fire, out_fire, out_last, produces, frame_free;

    b64le_frame u_frame (
        .i_held     (r_held),
        .i_fill     (r_fill),
        .i_byte     (i_in_data.data_byte),
        .i_final    (i_in_data.final_byte),
        .i_pos      (r_pos),
        .i_line_len (r_len),
        .o_frame    (n_frame),
        .o_next_pos (n_pos)
    );

    // A final byte or a third byte closes the group and needs the frame register.
    assign produces   = i_in_data.final_byte || (r_fill == 2'd2);
    assign out_last   = (r_idx == r_frame.cnt - 3'd1);
    assign out_fire   = r_fv && i_out_ready;
    assign frame_free = !r_fv || (out_fire && out_last);
    assign o_in_ready = !produces || frame_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid            = r_fv;
    assign o_out_data.out_char    = r_frame.chars[r_idx];
    assign o_out_data.run_last    = out_last;
    assign o_out_data.message_end = out_last && r_frame.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fill <= '0;
            r_pos  <= '0;
            r_len  <= LINE_LEN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (in_fire) begin
                if (produces) begin
                    r_held <= '0;
                    r_fill <= '0;
                    r_pos  <= n_pos;
                end else begin
                    r_held <= {r_held[7:0], i_in_data.data_byte};
                    r_fill <= r_fill + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv  <= 1'b0;
            r_idx <= '0;
        end else if (in_fire && produces) begin
            r_fv  <= 1'b1;
            r_idx <= '0;
        end else if (out_fire) begin
            if (out_last) begin
                r_fv <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Frame payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire && produces) begin
            r_frame <= n_frame;
        end
    end

    // Checks
    a_frame_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv |-> (r_frame.cnt == FRAME_SHORT || r_frame.cnt == FRAME_LONG))
        else $error("frame count out of range");

    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv |-> (r_idx < r_frame.cnt))
        else $error("output index beyond frame");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("group fill overflow");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.final_byte) |=> (r_fill == 2'd0 && r_pos == 8'd0 && r_fv))
        else $error("final byte did not close message");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && produces && r_fv) |-> (out_fire && out_last))
        else $error("frame overwritten before drained");

endmodule

// File: verif/base64_line_wrapped_encoder_top_test.sv
// Self-checking testbench for the line-wrapped base64 encoder: random messages, line lengths, stalls.
module base64_line_wrapped_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b64le_pkg::*;

    localparam int CLK_HALF        = 10;
    // Slack after the frame register drains, before touching the line length.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam logic FIN = 1'b1;
    localparam logic MID = 1'b0;

    // Standard alphabet; element 0 is the leftmost character of the literal.
    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Receiver back-pressure patterns, picked at random by the receiver.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_e;

    // DUT connections; every input starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // Encoder state as predicted; starts at the reset values.
    logic [15:0] group_bytes = '0;
    logic [1:0]  group_count = '0;
    logic [7:0]  line_col    = '0;
    logic [7:0]  line_len    = LINE_LEN_RESET;

    t_in_item  pending_bytes[$];   // bytes waiting for the sender
    t_out_item char_queue[$];      // characters the block still owes

    // Beat counters: sender side, monitor side.
    int in_sent        = 0;
    int in_beats       = 0;
    int out_beats      = 0;
    int cfg_beats      = 0;
    int crlf_seen      = 0;
    int messages_queued = 0;
    int error_count    = 0;

    // Sender burst shaping.
    int gap_left   = 0;
    int burst_left = 8;

    // Receiver shaping; hold-offs are requested by the stimulus and counted out by the receiver.
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    int          rx_tick       = 0;
    rx_pattern_e rx_mode       = RX_OPEN;

    base64_line_wrapped_encoder_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin : clock_gen
        forever #CLK_HALF clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last, input logic msg_end);
        char_queue.push_back({ch, last, msg_end});
    endtask

    // Byte-by-byte encoder prediction: collect up to three bytes, then emit four
    // characters, breaking the line with CR LF before any character that would
    // start past the line length.
    task automatic encode_byte(input t_in_item it);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] lim;
        logic [7:0] quad [4];
        int         k;
        // Byte that only fills the group: nothing comes out.
        if (!it.final_byte && group_count < 2'd2) begin
            group_bytes = {group_bytes[7:0], it.data_byte};
            group_count = group_count + 2'd1;
            return;
        end
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = 8'h00;
        case (group_count)
            2'd0: begin
                b0 = it.data_byte;
            end
            2'd1: begin
                b0 = group_bytes[7:0];
                b1 = it.data_byte;
            end
            default: begin
                b0 = group_bytes[15:8];
                b1 = group_bytes[7:0];
                b2 = it.data_byte;
            end
        endcase
        quad[0] = B64_ALPHABET[b0[7:2]];
        quad[1] = B64_ALPHABET[{b0[1:0], b1[7:4]}];
        quad[2] = B64_ALPHABET[{b1[3:0], b2[7:6]}];
        quad[3] = B64_ALPHABET[b2[5:0]];
        // Short final group gets '=' padding.
        if (group_count == 2'd0) quad[2] = CHAR_PAD;
        if (group_count != 2'd2) quad[3] = CHAR_PAD;
        // Lengths below the minimum behave as the minimum.
        lim = (line_len < LINE_LEN_MIN) ? LINE_LEN_MIN : line_len;
        for (k = 0; k < 4; k++) begin
            // Also fires when a shorter length was written mid-message.
            if (line_col >= lim) begin
                push_char(CHAR_CR, 1'b0, 1'b0);
                push_char(CHAR_LF, 1'b0, 1'b0);
                line_col = '0;
            end
            push_char(quad[k], k == 3, (k == 3) && it.final_byte);
            line_col = line_col + 8'd1;
        end
        group_bytes = '0;
        group_count = '0;
        // Next message starts a fresh line.
        if (it.final_byte) line_col = '0;
    endtask

    // Monitor: config beats, input beats (feed the prediction) and output beats
    // (checked against the oldest owed character), all sampled at the rising edge.
    // Input is handled before output so a same-edge result would still find its entry.
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                line_len = cfg_data;
                cfg_beats++;
            end
            if (in_valid && in_ready) begin
                encode_byte(in_data);
                in_beats++;
            end
            if (out_valid && out_ready) begin
                out_beats++;
                if (out_data.out_char === CHAR_CR) crlf_seen++;
                if (char_queue.size() == 0) begin
                    flag_error($sformatf("output beat %0d with nothing owed: %02h/%0b/%0b",
                        out_beats, out_data.out_char, out_data.run_last,
                        out_data.message_end));
                end else begin
                    want = char_queue.pop_front();
                    if (out_data.out_char !== want.out_char ||
                        out_data.run_last !== want.run_last ||
                        out_data.message_end !== want.message_end) begin
                        flag_error($sformatf(
                            "output beat %0d: char/last/end expected %02h/%0b/%0b got %02h/%0b/%0b",
                            out_beats, want.out_char, want.run_last, want.message_end,
                            out_data.out_char, out_data.run_last, out_data.message_end));
                    end
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps (a third of the
    // gaps are zero, so long unbroken runs happen). A beat on offer is held until
    // the monitor has counted it.
    always @(negedge clk) begin : sender
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && in_sent != in_beats) begin
            // beat still waiting for ready
        end else if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
            in_data  <= pending_bytes.pop_front();
            in_valid <= 1'b1;
            in_sent++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                burst_left = $urandom_range(1, 24);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: a long hold-off when requested, otherwise a pattern picked at random
    // for a random stretch (open, coin flip, one in four, mostly ready).
    always @(negedge clk) begin : receiver
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_pattern_e'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
                default:   out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // One message of len bytes; the last byte is flagged final unless left open.
    task automatic queue_message(input int len, input bit close);
        t_in_item it;
        int       k;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0:       it.data_byte = 8'h00;
                1:       it.data_byte = 8'hFF;
                default: it.data_byte = 8'($urandom_range(0, 255));
            endcase
            it.final_byte = close && (k == len - 1);
            pending_bytes.push_back(it);
        end
        if (close) messages_queued++;
    endtask

    // Mostly short messages, some longer ones; optionally the last one stays open.
    task automatic queue_random(input int nbytes, input bit leave_open);
        int left;
        int len;
        left = nbytes;
        while (left > 0) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (len > left) len = left;
            left -= len;
            queue_message(len, !(leave_open && left == 0));
        end
    endtask

    // Sender pause: nothing left to send, nothing owed, then the SETTLE_CYCLES wait.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_sent != in_beats || char_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_line_length(input logic [7:0] len);
        int target;
        target = cfg_beats + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        while (cfg_beats != target) @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] len, input int nbytes, input bit leave_open,
                             input bit hold_off);
        write_line_length(len);
        if (hold_off) hold_requests++;
        queue_random(nbytes, leave_open);
        wait_drained();
    endtask

    initial begin : stimulus
        int p;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset line length: single-byte and two-byte
        // padding, full groups, '+' and '/' corners, all-zero and all-one bytes,
        // mid-group bytes followed by a short final group.
        pending_bytes.push_back({8'h00, FIN});
        pending_bytes.push_back({8'hFF, FIN});
        pending_bytes.push_back({8'h00, MID});
        pending_bytes.push_back({8'hFF, FIN});
        pending_bytes.push_back({8'hFB, MID});
        pending_bytes.push_back({8'hEF, MID});
        pending_bytes.push_back({8'hBE, FIN});
        pending_bytes.push_back({8'hFF, MID});
        pending_bytes.push_back({8'hFF, MID});
        pending_bytes.push_back({8'hFF, MID});
        pending_bytes.push_back({8'hFF, FIN});
        pending_bytes.push_back({8'h00, MID});
        pending_bytes.push_back({8'h00, MID});
        pending_bytes.push_back({8'h00, MID});
        pending_bytes.push_back({8'hAA, MID});
        pending_bytes.push_back({8'h55, FIN});
        pending_bytes.push_back({8'h01, MID});
        pending_bytes.push_back({8'h80, FIN});
        pending_bytes.push_back({8'h7F, MID});
        pending_bytes.push_back({8'h80, MID});
        pending_bytes.push_back({8'h01, FIN});
        messages_queued += 8;
        wait_drained();

        // Shortest line, with the receiver held off so the input backs up.
        run_phase(8'd4, 20, 1'b0, 1'b1);

        // Longest line: one message long enough to wrap once at 255.
        write_line_length(8'd255);
        queue_message(195, 1'b1);
        queue_random(6, 1'b0);
        wait_drained();

        // Zero behaves as the minimum.
        run_phase(8'd0, 10, 1'b0, 1'b0);

        // Leave a 40-character line open, then shrink the length under it.
        write_line_length(8'd76);
        queue_random(6, 1'b0);
        queue_message(30, 1'b0);
        wait_drained();
        run_phase(8'd5, 15, 1'b0, 1'b1);

        // Just under the minimum.
        run_phase(8'd3, 10, 1'b1, 1'b0);

        for (p = 0; p < 3; p++)
            run_phase(8'($urandom_range(0, 255)), 6, 1'($urandom_range(0, 1)), 1'b0);

        run_phase(LINE_LEN_RESET, 6, 1'b0, 1'b0);

        if (char_queue.size() != 0)
            flag_error($sformatf("%0d characters never arrived", char_queue.size()));

        $display("Sent %0d bytes in %0d messages over %0d line length writes (4..255 and below 4);",
            in_beats, messages_queued, cfg_beats);
        $display("checked %0d characters, %0d line breaks, %0d receiver hold-offs, %0d mismatches.",
            out_beats, crlf_seen, holds_served, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: base64_line_wrapped_encoder_top.f
rtl/core/b64le_pkg.sv
rtl/core/b64le_frame.sv
rtl/core/base64_line_wrapped_encoder_top.sv
verif/base64_line_wrapped_encoder_top_test.sv
